>>> rtl/fbaa_pkg.sv
package fbaa_pkg;

    // address field widths
    localparam int CH_BITS  = 4;
    localparam int LUN_BITS = 4;
    localparam int PL_BITS  = 2;
    localparam int BLK_BITS = 12;

    localparam int ADDR_W = CH_BITS + LUN_BITS + PL_BITS + BLK_BITS;
    localparam int PL_SH  = BLK_BITS;
    localparam int LUN_SH = BLK_BITS + PL_BITS;
    localparam int CH_SH  = BLK_BITS + PL_BITS + LUN_BITS;

    // quotient of linear index by block count, and linear index widths
    localparam int Q_W   = LUN_BITS + PL_BITS;
    localparam int LIN_W = LUN_BITS + PL_BITS + BLK_BITS;
    localparam int TOT_W = LIN_W + 1;

    // configuration register widths
    localparam int NL_W = 5;
    localparam int NP_W = 3;
    localparam int NB_W = 13;

    localparam int AMT_W  = 32;
    localparam int MODE_W = 3;
    localparam int ST_W   = 3;
    localparam int DIST_W = 18;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 32;

    // modes
    localparam logic [MODE_W-1:0] MODE_PACK = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DLO  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DHI  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_CH = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_LN = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_PL = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_BK = 3'd4;
    localparam logic [ST_W-1:0] ST_OVF    = 3'd5;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_CHANNEL_ID  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LUN_START   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_LUN_COUNT   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_PLANE_COUNT = 3'd3;
    localparam logic [CIDX_W-1:0] REG_BLOCK_COUNT = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ADDR_W-1:0]   address;
        logic [AMT_W-1:0]    amount;
        logic [CH_BITS-1:0]  channel;
        logic [LUN_BITS-1:0] lun;
        logic [PL_BITS-1:0]  plane;
        logic [BLK_BITS-1:0] block;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] address_out;
        logic [DIST_W-1:0] distance;
        logic [ST_W-1:0]   status;
    } t_out_item;

    // effective geometry of the address space
    typedef struct packed {
        logic [CH_BITS-1:0]  cid;
        logic [LUN_BITS-1:0] ls;
        logic [NL_W-1:0]     nl;
        logic [NP_W-1:0]     np;
        logic [NB_W-1:0]     nb;
        logic [TOT_W-1:0]    total;
    } t_geom;

    // classified item handed from front to back
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [AMT_W-1:0]  amount;
        logic [ST_W-1:0]   st;
        logic [LIN_W-1:0]  lin;
        logic [ADDR_W-1:0] pack0;
    } t_work;

    // item inside the back pipeline
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [ST_W-1:0]   st;
        logic [LIN_W-1:0]  lin;
        logic [ADDR_W-1:0] pack0;
        logic [LIN_W-1:0]  rem;
        logic [Q_W-1:0]    quo;
    } t_div;

endpackage

>>> rtl/fbaa_front.sv
module fbaa_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  fbaa_pkg::t_in_item i_item,
    input  fbaa_pkg::t_geom  i_geom,
    input  logic             i_q_full,
    output logic             o_push,
    output fbaa_pkg::t_work  o_work
);

    logic                            fen;
    logic                            r_s1_valid;
    logic                            r_s2_valid;
    logic [fbaa_pkg::MODE_W-1:0]     r_mode;
    logic [fbaa_pkg::ADDR_W-1:0]     r_addr;
    logic [fbaa_pkg::AMT_W-1:0]      r_amount;
    logic [fbaa_pkg::ST_W-1:0]       r_st;
    logic [fbaa_pkg::Q_W-1:0]        r_idx;
    logic [fbaa_pkg::BLK_BITS-1:0]   r_blk;
    logic [fbaa_pkg::ADDR_W-1:0]     r_pack0;
    fbaa_pkg::t_work                 r_work;

    logic [fbaa_pkg::CH_BITS-1:0]    f_ch;
    logic [fbaa_pkg::LUN_BITS-1:0]   f_lun;
    logic [fbaa_pkg::PL_BITS-1:0]    f_pl;
    logic [fbaa_pkg::BLK_BITS-1:0]   f_blk;
    logic [fbaa_pkg::LUN_BITS-1:0]   rel;
    logic [fbaa_pkg::LUN_BITS+2:0]   p_rel;
    logic [fbaa_pkg::ST_W-1:0]       n_st;
    logic [fbaa_pkg::Q_W+fbaa_pkg::NB_W-1:0] p_lin;

    // front advances unless its last stage cannot hand off to the queue
    assign fen     = !(r_s2_valid && i_q_full);
    assign o_stall = !fen;
    assign o_push  = r_s2_valid && fen;
    assign o_work  = r_work;

    // pick fields: given fields for pack, decoded address otherwise
    always_comb begin
        if (i_item.mode == fbaa_pkg::MODE_PACK) begin
            f_ch  = i_item.channel;
            f_lun = i_item.lun;
            f_pl  = i_item.plane;
            f_blk = i_item.block;
        end else begin
            f_ch  = i_item.address[fbaa_pkg::CH_SH +: fbaa_pkg::CH_BITS];
            f_lun = i_item.address[fbaa_pkg::LUN_SH +: fbaa_pkg::LUN_BITS];
            f_pl  = i_item.address[fbaa_pkg::PL_SH +: fbaa_pkg::PL_BITS];
            f_blk = i_item.address[fbaa_pkg::BLK_BITS-1:0];
        end
    end

    // field checks in priority order
    assign rel = f_lun - i_geom.ls;
    always_comb begin
        if (i_item.mode > fbaa_pkg::MODE_DHI) begin
            n_st = fbaa_pkg::ST_OK;
        end else if (f_ch != i_geom.cid) begin
            n_st = fbaa_pkg::ST_BAD_CH;
        end else if (f_lun < i_geom.ls ||
                     fbaa_pkg::NL_W'(rel) >= i_geom.nl) begin
            n_st = fbaa_pkg::ST_BAD_LN;
        end else if (fbaa_pkg::NP_W'(f_pl) >= i_geom.np) begin
            n_st = fbaa_pkg::ST_BAD_PL;
        end else if (fbaa_pkg::NB_W'(f_blk) >= i_geom.nb) begin
            n_st = fbaa_pkg::ST_BAD_BK;
        end else begin
            n_st = fbaa_pkg::ST_OK;
        end
    end

    assign p_rel = (fbaa_pkg::LUN_BITS+3)'(rel) * (fbaa_pkg::LUN_BITS+3)'(i_geom.np);
    assign p_lin = (fbaa_pkg::Q_W+fbaa_pkg::NB_W)'(r_idx) *
                   (fbaa_pkg::Q_W+fbaa_pkg::NB_W)'(i_geom.nb);

    // stage 1: classify, partial index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fen) begin
            r_s1_valid <= i_valid;
        end
        if (fen) begin
            r_mode   <= i_item.mode;
            r_addr   <= i_item.address;
            r_amount <= i_item.amount;
            r_st     <= n_st;
            r_idx    <= fbaa_pkg::Q_W'(p_rel + (fbaa_pkg::LUN_BITS+3)'(f_pl));
            r_blk    <= f_blk;
            r_pack0  <= {f_ch, f_lun, f_pl, f_blk};
        end
    end

    // stage 2: full linear index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (fen) begin
            r_s2_valid <= r_s1_valid;
        end
        if (fen) begin
            r_work.mode   <= r_mode;
            r_work.addr   <= r_addr;
            r_work.amount <= r_amount;
            r_work.st     <= r_st;
            r_work.lin    <= fbaa_pkg::LIN_W'(p_lin + (fbaa_pkg::Q_W+fbaa_pkg::NB_W)'(r_blk));
            r_work.pack0  <= r_pack0;
        end
    end

endmodule

>>> rtl/fbaa_queue.sv
module fbaa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fbaa_pkg::t_work i_data,
    input  logic            i_pop,
    output fbaa_pkg::t_work o_data,
    output logic            o_full,
    output logic            o_empty
);

    fbaa_pkg::t_work r_mem [4];
    logic [1:0]      r_wp;
    logic [1:0]      r_rp;
    logic [2:0]      r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

endmodule

>>> rtl/fbaa_back.sv
module fbaa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbaa_pkg::t_geom    i_geom,
    input  logic               i_q_empty,
    input  fbaa_pkg::t_work    i_work,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output fbaa_pkg::t_out_item o_item
);

    localparam int QW = fbaa_pkg::Q_W;
    localparam int LW = fbaa_pkg::LIN_W;

    logic                 ben;
    fbaa_pkg::t_div       r_dv [QW+1];
    logic                 r_dvv [QW+1];
    logic                 r_out_valid;
    fbaa_pkg::t_out_item  r_out;

    fbaa_pkg::t_div       b0;
    logic [fbaa_pkg::TOT_W-1:0] room;
    fbaa_pkg::t_div       dn [QW];

    fbaa_pkg::t_div       fin;
    logic [QW-1:0]        q_np;
    logic [QW-1:0]        m_np;
    logic [QW+4:0]        p3;
    logic [fbaa_pkg::TOT_W-1:0] d_hi;
    fbaa_pkg::t_out_item  n_out;

    assign ben     = !(r_out_valid && i_stall);
    assign o_pop   = !i_q_empty && ben;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // stage 0: overflow check and new linear index
    assign room = i_geom.total - fbaa_pkg::TOT_W'(1) - fbaa_pkg::TOT_W'(i_work.lin);
    always_comb begin
        b0.mode  = i_work.mode;
        b0.addr  = i_work.addr;
        b0.st    = i_work.st;
        b0.lin   = i_work.lin;
        b0.pack0 = i_work.pack0;
        b0.quo   = '0;
        b0.rem   = i_work.lin;
        if (i_work.st == fbaa_pkg::ST_OK) begin
            if (i_work.mode == fbaa_pkg::MODE_ADD) begin
                if (i_work.amount > fbaa_pkg::AMT_W'(room)) begin
                    b0.st = fbaa_pkg::ST_OVF;
                end
                b0.rem = i_work.lin + LW'(i_work.amount);
            end else if (i_work.mode == fbaa_pkg::MODE_SUB) begin
                if (i_work.amount > fbaa_pkg::AMT_W'(i_work.lin)) begin
                    b0.st = fbaa_pkg::ST_OVF;
                end
                b0.rem = i_work.lin - LW'(i_work.amount);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else if (ben) begin
            r_dvv[0] <= o_pop;
        end
        if (ben) begin
            r_dv[0] <= b0;
        end
    end

    // restoring divide by block count, one quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int BIT = QW - 1 - j;
        logic [LW:0] dsr;
        assign dsr = (LW+1)'(i_geom.nb) << BIT;
        always_comb begin
            dn[j] = r_dv[j];
            if ({1'b0, r_dv[j].rem} >= dsr) begin
                dn[j].rem      = LW'({1'b0, r_dv[j].rem} - dsr);
                dn[j].quo[BIT] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[j+1] <= 1'b0;
            end else if (ben) begin
                r_dvv[j+1] <= r_dvv[j];
            end
            if (ben) begin
                r_dv[j+1] <= dn[j];
            end
        end
    end

    // split quotient into lun and plane digits
    assign fin = r_dv[QW];
    assign p3  = (QW+5)'(fin.quo) * (QW+5)'(43);
    always_comb begin
        case (i_geom.np)
            3'd1: begin
                q_np = fin.quo;
                m_np = '0;
            end
            3'd2: begin
                q_np = fin.quo >> 1;
                m_np = fin.quo & QW'(1);
            end
            3'd3: begin
                q_np = QW'(p3 >> 7);
                m_np = fin.quo - QW'(3 * QW'(p3 >> 7));
            end
            3'd4: begin
                q_np = fin.quo >> 2;
                m_np = fin.quo & QW'(3);
            end
            default: begin
                q_np = '0;
                m_np = '0;
            end
        endcase
    end

    // result assembly
    assign d_hi = i_geom.total - fbaa_pkg::TOT_W'(1) - fbaa_pkg::TOT_W'(fin.lin);
    always_comb begin
        n_out.address_out = fin.addr;
        n_out.distance    = '0;
        n_out.status      = fin.st;
        if (fin.st == fbaa_pkg::ST_OK) begin
            case (fin.mode)
                fbaa_pkg::MODE_PACK: n_out.address_out = fin.pack0;
                fbaa_pkg::MODE_ADD, fbaa_pkg::MODE_SUB: begin
                    n_out.address_out = {
                        fin.addr[fbaa_pkg::CH_SH +: fbaa_pkg::CH_BITS],
                        fbaa_pkg::LUN_BITS'(i_geom.ls + fbaa_pkg::LUN_BITS'(q_np)),
                        fbaa_pkg::PL_BITS'(m_np),
                        fin.rem[fbaa_pkg::BLK_BITS-1:0]};
                end
                fbaa_pkg::MODE_DLO: n_out.distance = fbaa_pkg::DIST_W'(fin.lin);
                fbaa_pkg::MODE_DHI: n_out.distance = fbaa_pkg::DIST_W'(d_hi);
                default: n_out.address_out = fin.addr;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ben) begin
            r_out_valid <= r_dvv[QW];
        end
        if (ben) begin
            r_out <= n_out;
        end
    end

endmodule

>>> rtl/flash_block_address_arith_top.sv
// Flash block address arithmetic: pack/check (mode 0), add/subtract a block
// count (1, 2) and distance from lowest/to highest address (3, 4) on packed
// channel/lun/plane/block addresses. One item is taken per clock unless the
// front stalls; a result passes 2 front stages, the queue, one overflow stage,
// 6 divider stages for the block-count quotient and the output register. A
// 4-entry queue lets front and back stall apart. The address-space size
// follows a geometry register change in the next cycle.
module flash_block_address_arith_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  fbaa_pkg::t_in_item         i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output fbaa_pkg::t_out_item        o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [fbaa_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [fbaa_pkg::CDAT_W-1:0] i_cfg_data
);

    logic [fbaa_pkg::CH_BITS-1:0]  r_cid;
    logic [fbaa_pkg::LUN_BITS-1:0] r_ls;
    logic [fbaa_pkg::NL_W-1:0]     r_lc;
    logic [fbaa_pkg::NP_W-1:0]     r_pc;
    logic [fbaa_pkg::NB_W-1:0]     r_bc;
    logic [fbaa_pkg::TOT_W-1:0]    r_total;

    logic [fbaa_pkg::NL_W-1:0]     room;
    logic [fbaa_pkg::NL_W+fbaa_pkg::NP_W-1:0] nlnp;
    fbaa_pkg::t_geom               geom;

    logic                          q_full;
    logic                          q_empty;
    logic                          push;
    logic                          pop;
    fbaa_pkg::t_work               w_in;
    fbaa_pkg::t_work               w_out;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cid <= '0;
            r_ls  <= '0;
            r_lc  <= 5'd16;
            r_pc  <= 3'd4;
            r_bc  <= 13'd4096;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fbaa_pkg::REG_CHANNEL_ID:  r_cid <= i_cfg_data[fbaa_pkg::CH_BITS-1:0];
                fbaa_pkg::REG_LUN_START:   r_ls  <= i_cfg_data[fbaa_pkg::LUN_BITS-1:0];
                fbaa_pkg::REG_LUN_COUNT:   r_lc  <= i_cfg_data[fbaa_pkg::NL_W-1:0];
                fbaa_pkg::REG_PLANE_COUNT: r_pc  <= i_cfg_data[fbaa_pkg::NP_W-1:0];
                fbaa_pkg::REG_BLOCK_COUNT: r_bc  <= i_cfg_data[fbaa_pkg::NB_W-1:0];
                default: ;
            endcase
        end
    end

    // effective counts, clipped so the highest address fits its fields
    assign room = fbaa_pkg::NL_W'(1 << fbaa_pkg::LUN_BITS) - fbaa_pkg::NL_W'(r_ls);
    assign geom.cid = r_cid;
    assign geom.ls  = r_ls;
    assign geom.nl  = (r_lc < room) ? r_lc : room;
    assign geom.np  = (r_pc < fbaa_pkg::NP_W'(1 << fbaa_pkg::PL_BITS)) ?
                      r_pc : fbaa_pkg::NP_W'(1 << fbaa_pkg::PL_BITS);
    assign geom.nb  = (r_bc < fbaa_pkg::NB_W'(1 << fbaa_pkg::BLK_BITS)) ?
                      r_bc : fbaa_pkg::NB_W'(1 << fbaa_pkg::BLK_BITS);
    assign geom.total = r_total;

    // size of the address space, registered
    assign nlnp = (fbaa_pkg::NL_W+fbaa_pkg::NP_W)'(geom.nl) *
                  (fbaa_pkg::NL_W+fbaa_pkg::NP_W)'(geom.np);
    always_ff @(posedge i_clk) begin
        r_total <= fbaa_pkg::TOT_W'(
            (fbaa_pkg::NL_W+fbaa_pkg::NP_W+fbaa_pkg::NB_W)'(nlnp) *
            (fbaa_pkg::NL_W+fbaa_pkg::NP_W+fbaa_pkg::NB_W)'(geom.nb));
    end

    fbaa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_item   (i_in),
        .i_geom   (geom),
        .i_q_full (q_full),
        .o_push   (push),
        .o_work   (w_in)
    );

    fbaa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_in),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fbaa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_q_empty (q_empty),
        .i_work    (w_out),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out)
    );

endmodule

>>> tb/flash_block_address_arith_top_test.sv
`timescale 1ns / 100ps

module flash_block_address_arith_top_test;
    import fbaa_pkg::*;

    // Expected results, in transfer order, with the field-wise check
    class addr_scoreboard;
        t_out_item pending[$];
        int        errors;

        function void note_input(t_out_item exp_item);
            pending.push_back(exp_item);
        endfunction

        task check_result(t_out_item got);
            t_out_item exp_item;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending", 0, longint'(got.address_out));
                return;
            end
            exp_item = pending.pop_front();
            if (got.address_out !== exp_item.address_out)
                report_mismatch("address_out", longint'(exp_item.address_out),
                                longint'(got.address_out));
            if (got.distance !== exp_item.distance)
                report_mismatch("distance", longint'(exp_item.distance),
                                longint'(got.distance));
            if (got.status !== exp_item.status)
                report_mismatch("status", longint'(exp_item.status), longint'(got.status));
        endtask

        task report_mismatch(string what, longint exp_v, longint got_v);
            $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
            errors++;
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CDAT_W-1:0] i_cfg_data = '0;

    addr_scoreboard sb = new();

    // shadow registers
    longint      cfg_cid, cfg_ls, cfg_nl, cfg_np, cfg_nb;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;

    flash_block_address_arith_top dut (.*);

    always #4 i_clk = ~i_clk;

    // Geometry as the block sees it, from the shadow registers
    function automatic void space_counts(output longint nl, output longint np,
                                         output longint nb);
        longint room;
        room = 16 - cfg_ls;
        nl = (cfg_nl < room) ? cfg_nl : room;
        np = (cfg_np < 4) ? cfg_np : 4;
        nb = (cfg_nb < 4096) ? cfg_nb : 4096;
    endfunction

    function automatic logic [ST_W-1:0] field_status(longint ch, longint ln, longint pl,
                                                     longint bk, longint nl, longint np,
                                                     longint nb);
        if (ch != cfg_cid) return ST_BAD_CH;
        if (ln < cfg_ls || ln - cfg_ls >= nl) return ST_BAD_LN;
        if (pl >= np) return ST_BAD_PL;
        if (bk >= nb) return ST_BAD_BK;
        return ST_OK;
    endfunction

    // Address arithmetic result for one input
    function automatic t_out_item address_calc(t_in_item it);
        t_out_item r;
        longint nl, np, nb, total, lin, nlin, t, ch, ln, pl, bk, amt;
        space_counts(nl, np, nb);
        total = nl * np * nb;
        amt = longint'(it.amount);
        r.address_out = it.address;
        r.distance = '0;
        r.status = ST_OK;
        if (it.mode == MODE_PACK) begin
            r.status = field_status(longint'(it.channel), longint'(it.lun),
                                    longint'(it.plane), longint'(it.block), nl, np, nb);
            if (r.status == ST_OK)
                r.address_out = {it.channel, it.lun, it.plane, it.block};
        end else if (it.mode <= MODE_DHI) begin
            ch = longint'(it.address[CH_SH +: CH_BITS]);
            ln = longint'(it.address[LUN_SH +: LUN_BITS]);
            pl = longint'(it.address[PL_SH +: PL_BITS]);
            bk = longint'(it.address[0 +: BLK_BITS]);
            r.status = field_status(ch, ln, pl, bk, nl, np, nb);
            if (r.status == ST_OK) begin
                lin = ((ln - cfg_ls) * np + pl) * nb + bk;
                if (it.mode == MODE_DLO) begin
                    r.distance = DIST_W'(lin);
                end else if (it.mode == MODE_DHI) begin
                    r.distance = DIST_W'(total - 1 - lin);
                end else begin
                    if (it.mode == MODE_ADD) begin
                        if (amt > total - 1 - lin) r.status = ST_OVF;
                        nlin = lin + amt;
                    end else begin
                        if (amt > lin) r.status = ST_OVF;
                        nlin = lin - amt;
                    end
                    if (r.status == ST_OK) begin
                        t = nlin / nb;
                        r.address_out = {CH_BITS'(ch), LUN_BITS'(cfg_ls + t / np),
                                         PL_BITS'(t % np), BLK_BITS'(nlin % nb)};
                    end
                end
            end
        end
        return r;
    endfunction

    // Register write over the configuration channel
    task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CHANNEL_ID:  cfg_cid = longint'(val & 'hF);
            REG_LUN_START:   cfg_ls = longint'(val & 'hF);
            REG_LUN_COUNT:   cfg_nl = longint'(val & 'h1F);
            REG_PLANE_COUNT: cfg_np = longint'(val & 'h7);
            REG_BLOCK_COUNT: cfg_nb = longint'(val & 'h1FFF);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_space(int unsigned cid, int unsigned ls, int unsigned nl,
                             int unsigned np, int unsigned nb);
        write_reg(REG_CHANNEL_ID, cid);
        write_reg(REG_LUN_START, ls);
        write_reg(REG_LUN_COUNT, nl);
        write_reg(REG_PLANE_COUNT, np);
        write_reg(REG_BLOCK_COUNT, nb);
        repeat (3) @(negedge i_clk);
    endtask

    // One input transfer; called at a falling edge, returns at one
    task automatic send_item(t_in_item it, bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(address_calc(it));
        @(negedge i_clk);
    endtask

    task automatic finish_burst;
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic int unsigned space_block(longint nb);
        return (nb > 0) ? $urandom_range(0, 32'(nb - 1)) : 0;
    endfunction

    // Random item, mostly inside the configured space
    function automatic t_in_item random_item();
        t_in_item it;
        logic [95:0] raw;
        longint nl, np, nb, total;
        int unsigned pick;
        space_counts(nl, np, nb);
        total = nl * np * nb;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.mode = ($urandom_range(0, 19) == 0) ? MODE_W'($urandom_range(5, 7))
                                               : MODE_W'($urandom_range(0, 4));
        if ($urandom_range(0, 4) != 0 && nl > 0 && np > 0 && nb > 0) begin
            it.channel = CH_BITS'(cfg_cid);
            it.lun = LUN_BITS'(cfg_ls + longint'($urandom_range(0, 32'(nl - 1))));
            it.plane = PL_BITS'($urandom_range(0, 32'(np - 1)));
            it.block = BLK_BITS'(space_block(nb));
            it.address = {it.channel, it.lun, it.plane, it.block};
            pick = $urandom_range(0, 5);
            if (pick == 0) it.amount = $urandom_range(0, 3);
            else if (pick <= 3) it.amount = $urandom_range(0, 32'(total));
            else if (pick == 4)
                it.amount = AMT_W'(total - 1 - longint'($urandom_range(0, 2)));
        end
        return it;
    endfunction

    function automatic t_in_item make_item(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                                           logic [AMT_W-1:0] amt);
        t_in_item it;
        it = '0;
        it.mode = m;
        it.address = a;
        it.amount = amt;
        it.channel = a[CH_SH +: CH_BITS];
        it.lun = a[LUN_SH +: LUN_BITS];
        it.plane = a[PL_SH +: PL_BITS];
        it.block = a[0 +: BLK_BITS];
        return it;
    endfunction

    // Stimulus
    initial begin
        cfg_cid = 0; cfg_ls = 0; cfg_nl = 16; cfg_np = 4; cfg_nb = 4096;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: full reset geometry, extremes, channel and overflow errors
        send_item(make_item(MODE_PACK, 22'h000000, 0), 0);
        send_item(make_item(MODE_PACK, 22'h0FFFFF, 0), 0);
        send_item(make_item(MODE_PACK, 22'h3FFFFF, 0), 0);
        send_item(make_item(MODE_ADD, 22'h000000, 32'd262143), 0);
        send_item(make_item(MODE_ADD, 22'h000000, 32'd262144), 0);
        send_item(make_item(MODE_ADD, 22'h0FFFFF, 32'hFFFFFFFF), 0);
        send_item(make_item(MODE_SUB, 22'h0FFFFF, 32'd262143), 0);
        send_item(make_item(MODE_SUB, 22'h000000, 32'd1), 0);
        send_item(make_item(MODE_DLO, 22'h0FFFFF, 0), 0);
        send_item(make_item(MODE_DHI, 22'h000000, 0), 0);
        send_item(make_item(3'd7, 22'h3FFFFF, 0), 0);
        finish_burst();
        // narrow space: lun, plane and block errors, carries across digits
        set_space(15, 15, 16, 3, 5);
        send_item(make_item(MODE_PACK, {4'd15, 4'd15, 2'd2, 12'd4}, 0), 0);
        send_item(make_item(MODE_PACK, {4'd15, 4'd14, 2'd0, 12'd0}, 0), 0);
        send_item(make_item(MODE_PACK, {4'd15, 4'd15, 2'd3, 12'd0}, 0), 0);
        send_item(make_item(MODE_PACK, {4'd15, 4'd15, 2'd0, 12'd5}, 0), 0);
        send_item(make_item(MODE_ADD, {4'd15, 4'd15, 2'd0, 12'd4}, 32'd1), 0);
        send_item(make_item(MODE_SUB, {4'd15, 4'd15, 2'd1, 12'd0}, 32'd1), 0);
        send_item(make_item(MODE_DHI, {4'd15, 4'd15, 2'd0, 12'd0}, 0), 0);
        finish_burst();
        // empty space: zero counts
        set_space(3, 4, 0, 0, 0);
        send_item(make_item(MODE_PACK, {4'd3, 4'd4, 2'd0, 12'd0}, 0), 0);
        send_item(make_item(MODE_DLO, {4'd3, 4'd4, 2'd0, 12'd0}, 0), 0);
        finish_burst();

        // random phases across geometries
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_space(0, 0, 16, 4, 4096);
                1: set_space(15, 15, 31, 7, 8191);
                2: set_space(1, 0, 1, 1, 1);
                default: set_space($urandom_range(0, 15), $urandom_range(0, 15),
                                   $urandom_range(1, 16), $urandom_range(1, 4),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                                               : $urandom_range(1, 20));
            endcase
            if (ph == 4) hold_off = 1'b1;
            for (int n = 0; n < 150; n++)
                send_item(random_item(), ph != 4);
            finish_burst();
        end
        stim_done = 1'b1;
    end

    // Output side: random stalls, one long hold-off
    initial begin
        int len;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold_off = 1'b0;
                i_out_stall <= 1'b1;
                for (int c = 0; c < 60; c++) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                i_out_stall <= 1'b1;
                repeat (len) @(negedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out);

    // Final verdict
    initial begin
        wait (stim_done);
        @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
rtl/fbaa_pkg.sv
rtl/fbaa_front.sv
rtl/fbaa_queue.sv
rtl/fbaa_back.sv
rtl/flash_block_address_arith_top.sv
tb/flash_block_address_arith_top_test.sv
